// ----- rtl/grid_coverage_walk_unit_assert.svh -----
// Assertion macros for the grid coverage walk checker.
// Plain text only; no dependencies.
`ifndef GRID_COVERAGE_WALK_UNIT_ASSERT_SVH
`define GRID_COVERAGE_WALK_UNIT_ASSERT_SVH

// same-cycle implication
`define GCW_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define GCW_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- rtl/gcw_pkg.sv -----
// Shared types and constants of the grid coverage walk unit.
// No dependencies.
package gcw_pkg;

	localparam int POS_W       = 6;
	localparam int CNT_OUT_W   = 13;
	localparam int DIR_W       = 2;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * POS_W + 3 + CNT_OUT_W);
	localparam int RST_DIM     = 8;

	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [CNT_OUT_W-1:0] cnt_out_t;
	typedef logic [DIR_W-1:0]     dir_t;
	typedef logic [CFG_IDX_W-1:0] reg_idx_t;

	localparam logic CMD_RESTART = 1'b0;

	localparam dir_t DIR_ROW_DEC = 2'd0;
	localparam dir_t DIR_ROW_INC = 2'd1;
	localparam dir_t DIR_COL_DEC = 2'd2;
	localparam dir_t DIR_COL_INC = 2'd3;

	localparam reg_idx_t REG_ROWS = 1'b0;
	localparam reg_idx_t REG_COLS = 1'b1;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} map_ctl_t;

	typedef struct packed {
		pos_t     pos_row;
		pos_t     pos_col;
		logic     moved;
		logic     on_path;
		logic     walk_done;
		cnt_out_t visit_count;
	} result_t;

endpackage

// ----- rtl/gcw_row_ram.sv -----
// Visited map: one word per grid row, synchronous read.
// Per-row valid flops give the cleared map (origin set) without a sweep.
// Depends on gcw_pkg.
module gcw_row_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gcw_pkg::map_ctl_t        ctl,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic [WIDTH-1:0]         rd_word
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [WIDTH-1:0] ORIGIN_WORD = {{(WIDTH-1){1'b0}}, 1'b1};

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rd_vld_q;
	logic             rd_zero_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_zero_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q  <= vld_q[rd_addr];
				rd_zero_q <= (rd_addr == AW'(0));
			end
		end
	end

	// unwritten row reads as cleared, row 0 keeps the origin
	assign rd_word = rd_vld_q ? rd_q : (rd_zero_q ? ORIGIN_WORD : '0);

endmodule

// ----- rtl/gcw_step_ctrl.sv -----
// Step sequencer: reads the three map rows around the current cell,
// picks the next cell, writes the row back and forms the result.
// Depends on gcw_pkg; drives gcw_row_ram.
module gcw_step_ctrl #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(MAX_ROWS+1)-1:0] rows,
	input  logic [$clog2(MAX_COLS+1)-1:0] cols,
	input  logic                          cfg_restart,
	input  logic                          item_valid,
	input  logic                          item_cmd,
	input  gcw_pkg::dir_t                 item_dir,
	output logic                          item_take,
	input  logic                          out_free,
	output logic                          res_valid,
	output gcw_pkg::result_t              res,
	output gcw_pkg::map_ctl_t             map_ctl,
	output logic [$clog2(MAX_ROWS)-1:0]   rd_addr,
	output logic [$clog2(MAX_ROWS)-1:0]   wr_addr,
	output logic [MAX_COLS-1:0]           wr_data,
	input  logic [MAX_COLS-1:0]           rd_word
);

	localparam int RA    = $clog2(MAX_ROWS);
	localparam int CA    = $clog2(MAX_COLS);
	localparam int RDW   = $clog2(MAX_ROWS+1);
	localparam int CDW   = $clog2(MAX_COLS+1);
	localparam int CNT_W = RDW + CDW;
	localparam logic [MAX_COLS-1:0] BIT0 = {{(MAX_COLS-1){1'b0}}, 1'b1};

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RD_UP  = 2'd1;
	localparam logic [1:0] ST_RD_CUR = 2'd2;
	localparam logic [1:0] ST_EXEC   = 2'd3;

	logic [1:0]          state_q, state_d;
	logic [RA-1:0]       row_q;
	logic [CA-1:0]       col_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	gcw_pkg::dir_t       dir_q;
	logic [MAX_COLS-1:0] dn_q;
	logic [MAX_COLS-1:0] up_q;

	logic                single, finished;
	logic                restart_go, step_go;
	logic [RA-1:0]       row_inc, row_dec;
	logic [CA-1:0]       col_inc, col_dec;
	logic                can_dn, can_up, can_rt, can_lf;
	logic                found, mark, complete;
	logic [RA-1:0]       nrow, wr_row;
	logic [CA-1:0]       ncol;
	logic [MAX_COLS-1:0] wr_word;
	logic [CNT_W-1:0]    cnt_nx, cells;

	assign single   = (rows == RDW'(1)) && (cols == CDW'(1));
	assign finished = done_q || single;

	assign row_inc = row_q + RA'(1);
	assign row_dec = row_q - RA'(1);
	assign col_inc = col_q + CA'(1);
	assign col_dec = col_q - CA'(1);
	assign can_dn  = (RDW'(row_q) + RDW'(1)) < rows;
	assign can_up  = (row_q != RA'(0));
	assign can_rt  = (CDW'(col_q) + CDW'(1)) < cols;
	assign can_lf  = (col_q != CA'(0));

	// neighbour choice; rd_word holds the current row in ST_EXEC
	always_comb begin
		found   = 1'b1;
		mark    = 1'b0;
		nrow    = row_q;
		ncol    = col_q;
		wr_row  = row_q;
		wr_word = rd_word;
		if (can_dn && !dn_q[col_q]) begin
			nrow    = row_inc;
			mark    = 1'b1;
			wr_row  = row_inc;
			wr_word = dn_q | (BIT0 << col_q);
		end else if (can_up && !up_q[col_q]) begin
			nrow    = row_dec;
			mark    = 1'b1;
			wr_row  = row_dec;
			wr_word = up_q | (BIT0 << col_q);
		end else if (can_rt && !rd_word[col_inc]) begin
			ncol    = col_inc;
			mark    = 1'b1;
			wr_word = rd_word | (BIT0 << col_inc);
		end else if (can_lf && !rd_word[col_dec]) begin
			ncol    = col_dec;
			mark    = 1'b1;
			wr_word = rd_word | (BIT0 << col_dec);
		end else begin
			// all open neighbours seen: fall back to the given direction
			case (dir_q)
				gcw_pkg::DIR_ROW_DEC: begin
					if (can_up) nrow = row_dec;
					else found = 1'b0;
				end
				gcw_pkg::DIR_ROW_INC: begin
					if (can_dn) nrow = row_inc;
					else found = 1'b0;
				end
				gcw_pkg::DIR_COL_DEC: begin
					if (can_lf) ncol = col_dec;
					else found = 1'b0;
				end
				gcw_pkg::DIR_COL_INC: begin
					if (can_rt) ncol = col_inc;
					else found = 1'b0;
				end
				default: begin
					found = 1'b0;
				end
			endcase
		end
	end

	assign cnt_nx   = cnt_q + CNT_W'(mark);
	assign cells    = CNT_W'(rows) * CNT_W'(cols);
	assign complete = found && (cnt_nx >= cells);

	always_comb begin
		state_d    = state_q;
		item_take  = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		map_ctl    = '0;
		rd_addr    = row_q;
		wr_addr    = wr_row;
		wr_data    = wr_word;
		restart_go = 1'b0;
		step_go    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && !cfg_restart) begin
					if (item_cmd == gcw_pkg::CMD_RESTART) begin
						if (out_free) begin
							item_take           = 1'b1;
							restart_go          = 1'b1;
							res_valid           = 1'b1;
							res.on_path         = 1'b1;
							res.walk_done       = single;
							res.visit_count     = gcw_pkg::cnt_out_t'(1);
						end
					end else if (finished) begin
						if (out_free) begin
							item_take           = 1'b1;
							res_valid           = 1'b1;
							res.pos_row         = gcw_pkg::pos_t'(row_q);
							res.pos_col         = gcw_pkg::pos_t'(col_q);
							res.walk_done       = 1'b1;
							res.visit_count     = gcw_pkg::cnt_out_t'(cnt_q);
						end
					end else begin
						item_take     = 1'b1;
						map_ctl.rd_en = 1'b1;
						rd_addr       = row_inc;
						state_d       = ST_RD_UP;
					end
				end
			end
			ST_RD_UP: begin
				map_ctl.rd_en = 1'b1;
				rd_addr       = row_dec;
				state_d       = ST_RD_CUR;
			end
			ST_RD_CUR: begin
				map_ctl.rd_en = 1'b1;
				rd_addr       = row_q;
				state_d       = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					step_go         = 1'b1;
					res_valid       = 1'b1;
					map_ctl.wr_en   = mark;
					res.pos_row     = gcw_pkg::pos_t'(nrow);
					res.pos_col     = gcw_pkg::pos_t'(ncol);
					res.moved       = found;
					res.on_path     = found && !complete;
					res.walk_done   = complete;
					res.visit_count = gcw_pkg::cnt_out_t'(cnt_nx);
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		map_ctl.clear = cfg_restart || restart_go;
		if (cfg_restart) begin
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			cnt_q   <= CNT_W'(1);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_restart || restart_go) begin
				row_q  <= '0;
				col_q  <= '0;
				cnt_q  <= CNT_W'(1);
				done_q <= 1'b0;
			end else if (step_go && found) begin
				row_q  <= nrow;
				col_q  <= ncol;
				cnt_q  <= cnt_nx;
				done_q <= complete;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			dir_q <= item_dir;
		end
		if (state_q == ST_RD_UP) begin
			dn_q <= rd_word;
		end
		if (state_q == ST_RD_CUR) begin
			up_q <= rd_word;
		end
	end

endmodule

// ----- rtl/grid_coverage_walk_unit.sv -----
// Grid coverage walk unit. A step command makes three reads of the
// visited-map memory (rows below, above and at the current cell, one per
// cycle through its single read port) and an update step that writes the
// row back and loads the result. Restart, and a step once the walk is done,
// are answered in the idle state without map reads; the input buffer refills
// only in the cycle after it empties, not in the cycle it hands one on.
// One input buffer and one output register let a new request in while a
// result waits. Restart and register writes clear the map at once through
// per-row valid flags, so there is no clearing pass after reset.
// Depends on gcw_pkg, gcw_row_ram and gcw_step_ctrl.
module grid_coverage_walk_unit #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  gcw_pkg::reg_idx_t                   cfg_idx,
	input  logic [gcw_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gcw_pkg::IN_TDATA_W-1:0]      s_tdata,  // [1:0] rand_dir
	input  logic                                s_tuser,  // [0] cmd
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [5:0] pos_row, [11:6] pos_col, [12] moved, [13] on_path,
	// [14] walk_done, [27:15] visit_count
	output logic [gcw_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int RA       = $clog2(MAX_ROWS);
	localparam int RDW      = $clog2(MAX_ROWS+1);
	localparam int CDW      = $clog2(MAX_COLS+1);
	localparam int RST_ROWS = (MAX_ROWS < gcw_pkg::RST_DIM) ? MAX_ROWS : gcw_pkg::RST_DIM;
	localparam int RST_COLS = (MAX_COLS < gcw_pkg::RST_DIM) ? MAX_COLS : gcw_pkg::RST_DIM;

	logic [RDW-1:0]         rows_q, rows_nx;
	logic [CDW-1:0]         cols_q, cols_nx;
	logic                   in_full_q;
	logic                   in_cmd_q;
	gcw_pkg::dir_t          in_dir_q;
	logic                   item_take;
	logic                   out_free;
	logic                   res_valid;
	gcw_pkg::result_t       res, out_q;
	logic                   m_valid_q;
	gcw_pkg::map_ctl_t      map_ctl;
	logic [RA-1:0]          rd_addr, wr_addr;
	logic [MAX_COLS-1:0]    wr_data, rd_word;

	// clamp written dimensions to 1..MAX
	always_comb begin
		if (cfg_data == '0) begin
			rows_nx = RDW'(1);
			cols_nx = CDW'(1);
		end else begin
			rows_nx = (32'(cfg_data) > 32'(MAX_ROWS)) ? RDW'(MAX_ROWS) : RDW'(cfg_data);
			cols_nx = (32'(cfg_data) > 32'(MAX_COLS)) ? CDW'(MAX_COLS) : CDW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RDW'(RST_ROWS);
			cols_q <= CDW'(RST_COLS);
		end else if (cfg_we) begin
			case (cfg_idx)
				gcw_pkg::REG_ROWS: rows_q <= rows_nx;
				gcw_pkg::REG_COLS: cols_q <= cols_nx;
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !in_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_full_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_full_q <= 1'b1;
		end else if (item_take) begin
			in_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_cmd_q <= s_tuser;
			in_dir_q <= s_tdata[gcw_pkg::DIR_W-1:0];
		end
	end

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{gcw_pkg::OUT_PAD_W{1'b0}}, out_q.visit_count, out_q.walk_done,
		out_q.on_path, out_q.moved, out_q.pos_col, out_q.pos_row};

	gcw_step_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.rows        (rows_q),
		.cols        (cols_q),
		.cfg_restart (cfg_we),
		.item_valid  (in_full_q),
		.item_cmd    (in_cmd_q),
		.item_dir    (in_dir_q),
		.item_take   (item_take),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res         (res),
		.map_ctl     (map_ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_word     (rd_word)
	);

	gcw_row_ram #(
		.DEPTH (MAX_ROWS),
		.WIDTH (MAX_COLS)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (map_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_word (rd_word)
	);

endmodule

// ----- rtl/gcw_checker.sv -----
// Port-level checks of the grid coverage walk unit, bound to the top level.
// Depends on gcw_pkg and grid_coverage_walk_unit_assert.svh.
`include "grid_coverage_walk_unit_assert.svh"

module gcw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [gcw_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic [5:0]  o_row;
	logic [5:0]  o_col;
	logic        o_moved;
	logic        o_on_path;
	logic        o_done;
	logic [12:0] o_cnt;

	assign o_row     = m_tdata[5:0];
	assign o_col     = m_tdata[11:6];
	assign o_moved   = m_tdata[12];
	assign o_on_path = m_tdata[13];
	assign o_done    = m_tdata[14];
	assign o_cnt     = m_tdata[27:15];

	`GCW_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`GCW_ASSERT_NXT(a_in_single, clk, arst_n, s_tvalid && s_tready, !s_tready, "input buffer took two requests")
	`GCW_ASSERT_IMP(a_restart_origin, clk, arst_n, m_tvalid && !o_moved && o_on_path, o_row == 6'd0 && o_col == 6'd0 && o_cnt == 13'd1, "restart result not at origin")
	`GCW_ASSERT_IMP(a_move_count, clk, arst_n, m_tvalid && o_moved, o_cnt >= 13'd2, "move with fewer than two cells seen")
	`GCW_ASSERT_IMP(a_path_not_done, clk, arst_n, m_tvalid && o_moved && o_on_path, !o_done, "completing move marked on path")

endmodule

bind grid_coverage_walk_unit gcw_checker u_gcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/sv/tb_top.sv -----
// Testbench for grid_coverage_walk_unit: directed table then random walk phases,
// every result checked against the table's expected value or a cycle-free walk
// predictor. Depends on gcw_pkg and the unit RTL.
module tb_top;

	localparam int GRID_MAX      = 64;
	localparam int RANDOM_ITEMS  = 1035;
	localparam int HOLD_CYCLES   = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam logic CMD_STEP    = ~gcw_pkg::CMD_RESTART;

	typedef enum bit {ROW_STEP, ROW_REG} plan_kind_t;

	typedef struct {
		plan_kind_t       kind;
		logic             sel;    // cmd for a step row, register index for a register row
		logic [6:0]       val;    // rand_dir or register value
		bit               typed;
		gcw_pkg::result_t want;
	} plan_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	gcw_pkg::reg_idx_t               cfg_idx;
	logic [gcw_pkg::CFG_W-1:0]       cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [gcw_pkg::IN_TDATA_W-1:0]  s_tdata;   // [1:0] rand_dir
	logic                            s_tuser;   // [0] cmd
	logic                            m_tvalid;
	logic                            m_tready;
	// [5:0] pos_row, [11:6] pos_col, [12] moved, [13] on_path,
	// [14] walk_done, [27:15] visit_count
	logic [gcw_pkg::OUT_TDATA_W-1:0] m_tdata;

	grid_coverage_walk_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// walk state as the block should hold it
	bit         visited_cells [GRID_MAX*GRID_MAX];
	int         walk_row;
	int         walk_col;
	int         cells_reached;
	bit         walk_over;
	logic [6:0] rows_reg;
	logic [6:0] cols_reg;

	gcw_pkg::result_t cell_reports_due [$];
	int               mismatch_count = 0;
	int               burst_left = 0;
	bit               hold_off_req = 0;
	plan_row_t        plan [23];

	function automatic int dim_used(logic [6:0] v);
		if (v == 0)
			return 1;
		if (v > GRID_MAX)
			return GRID_MAX;
		return int'(v);
	endfunction

	function automatic bit cell_seen(int r, int c);
		return visited_cells[r*GRID_MAX + c];
	endfunction

	function automatic gcw_pkg::result_t mk_rep(int r, int c, bit mv, bit op, bit dn, int cnt);
		gcw_pkg::result_t rep;
		rep.pos_row     = gcw_pkg::pos_t'(r);
		rep.pos_col     = gcw_pkg::pos_t'(c);
		rep.moved       = mv;
		rep.on_path     = op;
		rep.walk_done   = dn;
		rep.visit_count = gcw_pkg::cnt_out_t'(cnt);
		return rep;
	endfunction

	task automatic walk_restart();
		foreach (visited_cells[i])
			visited_cells[i] = 1'b0;
		visited_cells[0] = 1'b1;
		walk_row      = 0;
		walk_col      = 0;
		cells_reached = 1;
		walk_over     = (dim_used(rows_reg) * dim_used(cols_reg) <= 1);
	endtask

	task automatic apply_reg(gcw_pkg::reg_idx_t idx, logic [6:0] val);
		if (idx == gcw_pkg::REG_ROWS)
			rows_reg = val;
		else
			cols_reg = val;
		walk_restart();
	endtask

	task automatic advance_walk(input logic cmd, input gcw_pkg::dir_t dir,
		output gcw_pkg::result_t rep);
		int nrows;
		int ncols;
		int nr;
		int nc;
		int tr;
		int tc;
		bit found;
		nrows = dim_used(rows_reg);
		ncols = dim_used(cols_reg);
		nr    = walk_row;
		nc    = walk_col;
		found = 1'b1;
		if (cmd == gcw_pkg::CMD_RESTART) begin
			walk_restart();
			rep = mk_rep(0, 0, 1'b0, 1'b1, walk_over, 1);
		end else if (walk_over) begin
			rep = mk_rep(walk_row, walk_col, 1'b0, 1'b0, 1'b1, cells_reached);
		end else begin
			if (walk_row + 1 < nrows && !cell_seen(walk_row + 1, walk_col)) begin
				nr = walk_row + 1;
			end else if (walk_row >= 1 && !cell_seen(walk_row - 1, walk_col)) begin
				nr = walk_row - 1;
			end else if (walk_col + 1 < ncols && !cell_seen(walk_row, walk_col + 1)) begin
				nc = walk_col + 1;
			end else if (walk_col >= 1 && !cell_seen(walk_row, walk_col - 1)) begin
				nc = walk_col - 1;
			end else begin
				// boxed in: fall back on the supplied direction
				tr = walk_row;
				tc = walk_col;
				case (dir)
					gcw_pkg::DIR_ROW_DEC: tr = walk_row - 1;
					gcw_pkg::DIR_ROW_INC: tr = walk_row + 1;
					gcw_pkg::DIR_COL_DEC: tc = walk_col - 1;
					default:              tc = walk_col + 1;
				endcase
				if (tr < 0 || tc < 0 || tr >= nrows || tc >= ncols) begin
					found = 1'b0;
				end else begin
					nr = tr;
					nc = tc;
				end
			end
			if (!found) begin
				rep = mk_rep(walk_row, walk_col, 1'b0, 1'b0, 1'b0, cells_reached);
			end else begin
				if (!cell_seen(nr, nc)) begin
					visited_cells[nr*GRID_MAX + nc] = 1'b1;
					cells_reached++;
				end
				walk_row = nr;
				walk_col = nc;
				if (cells_reached >= nrows * ncols)
					walk_over = 1'b1;
				rep = mk_rep(walk_row, walk_col, 1'b1, !walk_over, walk_over, cells_reached);
			end
		end
	endtask

	task automatic report_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: windows of differing stall density, one long hold-off on request
	initial begin
		int window;
		int stall_pct;
		int hold;
		window    = 0;
		stall_pct = 0;
		hold      = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold         = HOLD_CYCLES;
				m_tready    <= 1'b0;
			end else begin
				if (window == 0) begin
					window = $urandom_range(16, 64);
					case ($urandom_range(0, 2))
						0:       stall_pct = 0;
						1:       stall_pct = 25;
						default: stall_pct = 75;
					endcase
				end
				window--;
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		gcw_pkg::result_t want;
		gcw_pkg::result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.pos_row     = m_tdata[5:0];
			got.pos_col     = m_tdata[11:6];
			got.moved       = m_tdata[12];
			got.on_path     = m_tdata[13];
			got.walk_done   = m_tdata[14];
			got.visit_count = m_tdata[27:15];
			if (cell_reports_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = cell_reports_due.pop_front();
				report_field("pos_row", want.pos_row, got.pos_row);
				report_field("pos_col", want.pos_col, got.pos_col);
				report_field("moved", want.moved, got.moved);
				report_field("on_path", want.on_path, got.on_path);
				report_field("walk_done", want.walk_done, got.walk_done);
				report_field("visit_count", want.visit_count, got.visit_count);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 10);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		burst_left--;
	endtask

	task automatic send_request(logic cmd, gcw_pkg::dir_t dir, bit typed,
		gcw_pkg::result_t want);
		gcw_pkg::result_t rep;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(gcw_pkg::IN_TDATA_W-gcw_pkg::DIR_W){1'b0}}, dir};
		do @(posedge clk); while (!s_tready);
		advance_walk(cmd, dir, rep);
		cell_reports_due = {cell_reports_due, (typed ? want : rep)};
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (cell_reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(gcw_pkg::reg_idx_t idx, logic [6:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int n;
		int steps;
		int phase;
		logic [6:0] rv;
		logic [6:0] cv;
		logic cmd;

		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = gcw_pkg::REG_ROWS;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_STEP;
		rows_reg = 7'(gcw_pkg::RST_DIM);
		cols_reg = 7'(gcw_pkg::RST_DIM);
		walk_restart();

		plan = '{
			'{ROW_STEP, gcw_pkg::CMD_RESTART, gcw_pkg::DIR_COL_INC, 1,
				mk_rep(0, 0, 0, 1, 0, 1)},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_ROW_DEC, 1, mk_rep(1, 0, 1, 1, 0, 2)},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_ROW_INC, 0, '0},
			// single cell: done at once
			'{ROW_REG,  gcw_pkg::REG_ROWS, 7'd1, 0, '0},
			'{ROW_REG,  gcw_pkg::REG_COLS, 7'd1, 0, '0},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_COL_DEC, 1, mk_rep(0, 0, 0, 0, 1, 1)},
			'{ROW_STEP, gcw_pkg::CMD_RESTART, gcw_pkg::DIR_ROW_INC, 1,
				mk_rep(0, 0, 0, 1, 1, 1)},
			// zero rows read as one: 1x2, completing move then step after done
			'{ROW_REG,  gcw_pkg::REG_ROWS, 7'd0, 0, '0},
			'{ROW_REG,  gcw_pkg::REG_COLS, 7'd2, 0, '0},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_ROW_DEC, 1, mk_rep(0, 1, 1, 0, 1, 2)},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_COL_INC, 1, mk_rep(0, 1, 0, 0, 1, 2)},
			// oversize values read as the maximum
			'{ROW_REG,  gcw_pkg::REG_ROWS, 7'd127, 0, '0},
			'{ROW_REG,  gcw_pkg::REG_COLS, 7'd127, 0, '0},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_COL_DEC, 1, mk_rep(1, 0, 1, 1, 0, 2)},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_ROW_INC, 0, '0},
			'{ROW_STEP, gcw_pkg::CMD_RESTART, gcw_pkg::DIR_ROW_DEC, 1,
				mk_rep(0, 0, 0, 1, 0, 1)},
			'{ROW_REG,  gcw_pkg::REG_ROWS, 7'd2, 0, '0},
			'{ROW_REG,  gcw_pkg::REG_COLS, 7'd2, 0, '0},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_ROW_DEC, 1, mk_rep(1, 0, 1, 1, 0, 2)},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_COL_DEC, 1, mk_rep(1, 1, 1, 1, 0, 3)},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_ROW_INC, 1, mk_rep(0, 1, 1, 0, 1, 4)},
			'{ROW_STEP, CMD_STEP, gcw_pkg::DIR_COL_INC, 1, mk_rep(0, 1, 0, 0, 1, 4)},
			'{ROW_STEP, gcw_pkg::CMD_RESTART, gcw_pkg::DIR_COL_INC, 1,
				mk_rep(0, 0, 0, 1, 0, 1)}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(plan[i].sel, plan[i].val);
			end else begin
				pace();
				send_request(plan[i].sel, plan[i].val[1:0], plan[i].typed, plan[i].want);
			end
		end

		// walks on assorted grids, each of up to the cell count plus three steps, the odd restart mid-walk
		n     = 0;
		phase = 0;
		while (n < RANDOM_ITEMS) begin
			if (phase == 0) begin
				rv = 7'd64;
				cv = 7'd1;
			end else if (phase == 1) begin
				rv = 7'd1;
				cv = 7'd64;
			end else if ($urandom_range(0, 9) == 0) begin
				rv = 7'($urandom_range(0, 127));
				cv = 7'($urandom_range(0, 127));
			end else begin
				rv = 7'($urandom_range(1, 8));
				cv = 7'($urandom_range(1, 8));
			end
			wait_idle();
			write_reg(gcw_pkg::REG_ROWS, rv);
			write_reg(gcw_pkg::REG_COLS, cv);
			steps = dim_used(rv) * dim_used(cv) + $urandom_range(0, 3);
			if (steps > 120)
				steps = 120;
			if (steps > RANDOM_ITEMS - n)
				steps = RANDOM_ITEMS - n;
			if (phase == 0)
				hold_off_req = 1'b1;
			repeat (steps) begin
				pace();
				cmd = ($urandom_range(0, 39) == 0) ? gcw_pkg::CMD_RESTART : CMD_STEP;
				send_request(cmd, gcw_pkg::dir_t'($urandom_range(0, 3)), 1'b0, '0);
				n++;
			end
			phase++;
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
